/* src/att_pkg.sv */
// Shared types and constants for the accelerometer tilt-angle block.
// Used by att_front, att_back and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package att_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ANGLE_W  = 16;
   localparam int SQ_W     = 32;   // sum of two squares
   localparam int ROOT_W   = 32;   // magnitude with 16 fraction bits
   localparam int REM_W    = 34;   // square root remainder
   localparam int XY_W     = 35;   // CORDIC vector components
   localparam int Z_W      = 30;   // CORDIC angle, degrees times 2^20
   localparam int Z_FRAC   = 20;
   localparam int TAB_LEN  = 24;
   localparam int LANES    = 3;

   localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90 * (2 ** Z_FRAC));

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle_x;
      logic [ANGLE_W-1:0] angle_y;
      logic [ANGLE_W-1:0] angle_z;
      logic               zero_vector;
   } rsp_type;

   // Word passed from the magnitude front end to the CORDIC back end.
   typedef struct packed {
      logic [LANES-1:0][SAMPLE_W-1:0] axis;
      logic [LANES-1:0][ROOT_W-1:0]   mag;
      logic                           zero;
   } mid_type;

   // atan(2^-i) in degrees times 2^20, rounded to nearest.
   function automatic logic [Z_W-1:0] atan_tab(input int idx);
      logic [Z_W-1:0] val;
      begin
         unique case (idx)
            0:  val = Z_W'(47185920);
            1:  val = Z_W'(27855475);
            2:  val = Z_W'(14718068);
            3:  val = Z_W'(7471121);
            4:  val = Z_W'(3750058);
            5:  val = Z_W'(1876857);
            6:  val = Z_W'(938658);
            7:  val = Z_W'(469357);
            8:  val = Z_W'(234682);
            9:  val = Z_W'(117342);
            10: val = Z_W'(58671);
            11: val = Z_W'(29335);
            12: val = Z_W'(14668);
            13: val = Z_W'(7334);
            14: val = Z_W'(3667);
            15: val = Z_W'(1833);
            16: val = Z_W'(917);
            17: val = Z_W'(458);
            18: val = Z_W'(229);
            19: val = Z_W'(115);
            20: val = Z_W'(57);
            21: val = Z_W'(29);
            22: val = Z_W'(14);
            23: val = Z_W'(7);
            default: val = '0;
         endcase
         return val;
      end
   endfunction

endpackage
`default_nettype wire

/* src/att_fifo.sv */
// Small first-in first-out queue of words with a valid/ready interface.
// Generic; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module att_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_ready,
   output logic [WIDTH-1:0]      rd_data
);
   localparam int DEPTH = 2 ** DEPTH_LOG2;

   logic [WIDTH-1:0]      mem_ff [0:DEPTH-1];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_wr, do_rd;

   assign wr_ready = (count_ff != (DEPTH_LOG2+1)'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

/* src/att_front.sv */
// Front end: squares, sums of squares and a pipelined exact square root,
// one result bit per stage. Depends on att_pkg.
`timescale 1ns / 1ps
`default_nettype none
module att_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  att_pkg::req_type    in_item,
   output logic                out_valid,
   input  wire logic           out_ready,
   output att_pkg::mid_type    out_item
);
   import att_pkg::*;

   localparam int LAST = ROOT_W + 1;

   logic [LANES-1:0][SAMPLE_W-1:0] v_ff    [0:LAST];
   logic                           zero_ff [0:LAST];
   logic                           vld_ff  [0:LAST];
   logic [LANES-1:0][SQ_W-1:0]     sq_ff   [0:LAST];
   logic [LANES-1:0][ROOT_W-1:0]   q_ff    [1:LAST];
   logic [LANES-1:0][REM_W-1:0]    r_ff    [1:LAST];
   logic                           adv;

   // The whole pipeline moves together; it holds only when its last word waits.
   assign adv      = !vld_ff[LAST] || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LAST; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s <= LAST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // Stage 0: squares.
   always_ff @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] a;
      logic signed [SQ_W-1:0]     p;
      if (adv) begin
         v_ff[0][0] <= in_item.accel_x;
         v_ff[0][1] <= in_item.accel_y;
         v_ff[0][2] <= in_item.accel_z;
         zero_ff[0] <= (in_item.accel_x == '0) && (in_item.accel_y == '0)
                       && (in_item.accel_z == '0);
         for (int l = 0; l < LANES; l++) begin
            unique case (l)
               0:       a = in_item.accel_x;
               1:       a = in_item.accel_y;
               default: a = in_item.accel_z;
            endcase
            p = a * a;
            sq_ff[0][l] <= SQ_W'(unsigned'(p));
         end
      end
   end

   // Stage 1: each lane gets the sum of the other two squares.
   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff[1]     <= v_ff[0];
         zero_ff[1]  <= zero_ff[0];
         sq_ff[1][0] <= sq_ff[0][1] + sq_ff[0][2];
         sq_ff[1][1] <= sq_ff[0][0] + sq_ff[0][2];
         sq_ff[1][2] <= sq_ff[0][0] + sq_ff[0][1];
         q_ff[1]     <= '0;
         r_ff[1]     <= '0;
      end
   end

   // Root stages: the radicand is the sum shifted up by 32, so its low pairs are zero.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [1:0]          pair;
         logic [REM_W+1:0]    trial, sub;
         logic                take;
         logic [REM_W-1:0]    r_in;
         logic [ROOT_W-1:0]   q_in;

         if (2 * k < SQ_W) begin : g_bits
            assign pair = sq_ff[k+1][l][SQ_W-1-2*k -: 2];
         end else begin : g_zero
            assign pair = 2'b00;
         end

         assign trial = {r_ff[k+1][l], pair};
         assign sub   = (REM_W+2)'({q_ff[k+1][l], 2'b01});
         assign take  = (trial >= sub);
         assign r_in  = take ? REM_W'(trial - sub) : REM_W'(trial);
         assign q_in  = {q_ff[k+1][l][ROOT_W-2:0], take};

         always_ff @(posedge clock) begin
            if (adv) begin
               r_ff[k+2][l] <= r_in;
               q_ff[k+2][l] <= q_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            v_ff[k+2]    <= v_ff[k+1];
            zero_ff[k+2] <= zero_ff[k+1];
            sq_ff[k+2]   <= sq_ff[k+1];
         end
      end
   end

   assign out_valid     = vld_ff[LAST];
   assign out_item.axis = v_ff[LAST];
   assign out_item.mag  = q_ff[LAST];
   assign out_item.zero = zero_ff[LAST];
endmodule
`default_nettype wire

/* src/att_back.sv */
// Back end: quadrant fold, pipelined CORDIC vectoring per axis, rounding and clamp.
// Depends on att_pkg.
`timescale 1ns / 1ps
`default_nettype none
module att_back #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int CORDIC_STAGES   = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  att_pkg::mid_type    in_item,
   output logic                out_valid,
   input  wire logic           out_ready,
   output att_pkg::rsp_type    out_item
);
   import att_pkg::*;

   localparam int NS    = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
   localparam int LAST  = NS + 1;
   localparam int SHIFT = Z_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [Z_W:0] HALF  = (Z_W+1)'(2 ** (SHIFT - 1));
   localparam logic signed [Z_W:0] LIMIT = (Z_W+1)'(180 * (2 ** ANGLE_FRAC_BITS));

   logic signed [XY_W-1:0] x_ff [0:NS][0:LANES-1];
   logic signed [XY_W-1:0] y_ff [0:NS][0:LANES-1];
   logic signed [Z_W-1:0]  z_ff [0:NS][0:LANES-1];
   logic                   zero_ff [0:NS];
   logic                   vld_ff  [0:LAST];
   logic [LANES-1:0][ANGLE_W-1:0] ang_ff;
   logic                   zv_ff;
   logic                   adv;

   assign adv      = !vld_ff[LAST] || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LAST; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s <= LAST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [XY_W-1:0] ax, mg;
      logic signed [Z_W:0]    zr, zs;

      assign ax = {{(XY_W-SAMPLE_W-16){in_item.axis[l][SAMPLE_W-1]}},
                   in_item.axis[l], 16'b0};
      assign mg = {{(XY_W-ROOT_W){1'b0}}, in_item.mag[l]};

      // A negative axis value is turned by a quarter so the vector starts in the right half.
      always_ff @(posedge clock) begin
         if (adv) begin
            if (in_item.axis[l][SAMPLE_W-1]) begin
               x_ff[0][l] <= mg;
               y_ff[0][l] <= -ax;
               z_ff[0][l] <= Z_QUARTER;
            end else begin
               x_ff[0][l] <= ax;
               y_ff[0][l] <= mg;
               z_ff[0][l] <= '0;
            end
         end
      end

      for (genvar i = 0; i < NS; i++) begin : g_stage
         logic signed [XY_W-1:0] dx, dy;
         logic signed [Z_W-1:0]  t;

         assign dx = y_ff[i][l] >>> i;
         assign dy = x_ff[i][l] >>> i;
         assign t  = $signed(atan_tab(i));

         always_ff @(posedge clock) begin
            if (adv) begin
               if (!y_ff[i][l][XY_W-1]) begin
                  x_ff[i+1][l] <= x_ff[i][l] + dx;
                  y_ff[i+1][l] <= y_ff[i][l] - dy;
                  z_ff[i+1][l] <= z_ff[i][l] + t;
               end else begin
                  x_ff[i+1][l] <= x_ff[i][l] - dx;
                  y_ff[i+1][l] <= y_ff[i][l] + dy;
                  z_ff[i+1][l] <= z_ff[i][l] - t;
               end
            end
         end
      end

      assign zr = {z_ff[NS][l][Z_W-1], z_ff[NS][l]} + HALF;
      assign zs = zr >>> SHIFT;

      always_ff @(posedge clock) begin
         if (adv) begin
            if (zero_ff[NS] || zs < 0) begin
               ang_ff[l] <= '0;
            end else if (zs > LIMIT) begin
               ang_ff[l] <= LIMIT[ANGLE_W-1:0];
            end else begin
               ang_ff[l] <= zs[ANGLE_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= in_item.zero;
         for (int s = 1; s <= NS; s++) begin
            zero_ff[s] <= zero_ff[s-1];
         end
         zv_ff <= zero_ff[NS];
      end
   end

   assign out_valid            = vld_ff[LAST];
   assign out_item.angle_x     = ang_ff[0];
   assign out_item.angle_y     = ang_ff[1];
   assign out_item.angle_z     = ang_ff[2];
   assign out_item.zero_vector = zv_ff;
endmodule
`default_nettype wire

/* src/accel_tilt_angles.sv */
// Top level of the accelerometer tilt-angle block: front end, word queue, back end,
// result queue. Depends on att_pkg, att_front, att_fifo and att_back.
//
//   channel   ports                       direction   word
//   request   push, full, req_item        in          one x/y/z sample
//   response  pop, empty, rsp_item        out         three angles and zero flag
//
// One sample is accepted every cycle while full is low.
// Each sample passes through the square-root pipeline, the word queue, the CORDIC pipeline
// and the result queue; both queues hold four words.
// Reset clears only valid bits and queue pointers and counts; there is no clearing pass.
// When pop stays low the result queue fills, then each pipeline holds in turn.
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_angles #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int CORDIC_STAGES   = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  att_pkg::req_type  req_item,
   output logic              empty,
   input  wire logic         pop,
   output att_pkg::rsp_type  rsp_item
);
   import att_pkg::*;

   localparam int LIM = 180 * (2 ** ANGLE_FRAC_BITS);
   localparam logic LIM_FITS = (LIM < (2 ** ANGLE_W));
   localparam logic [ANGLE_W-1:0] LIM16 = ANGLE_W'(LIM);

   logic    front_ready, front_valid, mid_ready, mid_valid, back_ready;
   logic    back_valid, rsp_ready, rsp_valid;
   mid_type front_item, mid_item;
   rsp_type back_item;

   assign full = !front_ready;

   att_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (front_ready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (mid_ready),
      .out_item  (front_item)
   );

   att_fifo #(
      .WIDTH      ($bits(mid_type)),
      .DEPTH_LOG2 (2)
   ) u_mid_q (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (mid_ready),
      .wr_data  (front_item),
      .rd_valid (mid_valid),
      .rd_ready (back_ready),
      .rd_data  (mid_item)
   );

   att_back #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STAGES   (CORDIC_STAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (back_ready),
      .in_item   (mid_item),
      .out_valid (back_valid),
      .out_ready (rsp_ready),
      .out_item  (back_item)
   );

   att_fifo #(
      .WIDTH      ($bits(rsp_type)),
      .DEPTH_LOG2 (2)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (back_valid),
      .wr_ready (rsp_ready),
      .wr_data  (back_item),
      .rd_valid (rsp_valid),
      .rd_ready (pop),
      .rd_data  (rsp_item)
   );

   assign empty = !rsp_valid;

   a_zero_gives_zero_angles: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.zero_vector |->
         rsp_item.angle_x == '0 && rsp_item.angle_y == '0 && rsp_item.angle_z == '0)
      else $error("zero vector word carries a nonzero angle");

   a_angle_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty && LIM_FITS |->
         rsp_item.angle_x <= LIM16 && rsp_item.angle_y <= LIM16
         && rsp_item.angle_z <= LIM16)
      else $error("angle above 180 degrees");

   a_idle_front_not_full: assert property (@(posedge clock) disable iff (reset)
      !front_valid |-> !full)
      else $error("front end stalls with no word at its end");
endmodule
`default_nettype wire
